@@ rtl/core/mie_pkg.sv @@
// ----------------------------------------------------------------------------
// mie_pkg: shared types and constants for the machine interrupt entry block
// Item layouts, CSR bit positions and function codes used by every stage.
// ----------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

  localparam int unsigned XLEN      = 64;
  localparam int unsigned CodeW     = 31;
  localparam int unsigned InDataW   = 6 * XLEN;
  localparam int unsigned OutDataW  = 5 * XLEN;

  // mstatus / mie / mip bit positions
  localparam int unsigned MieIdx    = 3;
  localparam int unsigned MpieIdx   = 7;
  localparam int unsigned MppLoIdx  = 11;
  localparam int unsigned MppHiIdx  = 12;

  // Interrupt codes with a dedicated source bit
  localparam logic [CodeW-1:0] CodeSoft  = 31'd3;
  localparam logic [CodeW-1:0] CodeTimer = 31'd7;
  localparam int unsigned      SoftIdx   = 3;
  localparam int unsigned      TimerIdx  = 7;
  localparam int unsigned      ExtIdx    = 11;

  localparam logic [1:0] ModeVectored = 2'd1;

  typedef enum logic {
    FuncRaise = 1'b0,
    FuncCheck = 1'b1
  } func_e;

  typedef struct packed {
    func_e            func;
    logic [XLEN-1:0]  cause_in;
    logic [XLEN-1:0]  status_in;
    logic [XLEN-1:0]  enable_in;
    logic [XLEN-1:0]  pend_in;
    logic [XLEN-1:0]  vector_in;
    logic [XLEN-1:0]  pc_in;
  } in_item_t;

  typedef struct packed {
    logic             taken;
    logic             pend_write;
    logic [XLEN-1:0]  pend_out;
    logic [XLEN-1:0]  status_out;
    logic [XLEN-1:0]  epc_out;
    logic [XLEN-1:0]  cause_out;
    logic [XLEN-1:0]  pc_out;
  } res_item_t;

  // Pipeline control between the stages
  typedef struct packed {
    logic valid;
    logic advance;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/mie_in_stage.sv @@
// ----------------------------------------------------------------------------
// mie_in_stage: input register
// Captures one item per cycle from the slave side whenever the stage is empty
// or moving on in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_in_stage
  import mie_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire in_item_t in_item_i,
  output logic          in_ready_o,
  input  wire logic     advance_i,
  output pipe_ctrl_t    ctrl_o,
  output in_item_t      item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign ctrl_o.valid   = valid_q;
  assign ctrl_o.advance = advance_i;
  assign item_o         = item_q;

endmodule

`default_nettype wire

@@ rtl/core/mie_trap_logic.sv @@
// ----------------------------------------------------------------------------
// mie_trap_logic: interrupt state and trap decision
// Holds the pending flag, the release flag and the latched cause, and works
// out the result of the registered item in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_trap_logic
  import mie_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pipe_ctrl_t ctrl_i,
  input  wire in_item_t   item_i,
  output res_item_t       res_o
);

  logic             pending_q, pending_d;
  logic             released_q, released_d;
  logic [XLEN-1:0]  cause_q, cause_d;

  logic             fire;
  logic [CodeW-1:0] code;
  logic [XLEN-1:0]  src_mask;
  logic [XLEN-1:0]  base;
  logic [XLEN-1:0]  new_status;
  logic             take;
  logic             release_now;

  assign fire = ctrl_i.valid && ctrl_i.advance;
  assign code = cause_q[CodeW-1:0];

  always_comb begin
    src_mask = '0;
    case (code)
      CodeSoft:  src_mask[SoftIdx]  = 1'b1;
      CodeTimer: src_mask[TimerIdx] = 1'b1;
      default:   src_mask[ExtIdx]   = 1'b1;
    endcase
  end

  assign base = {item_i.vector_in[XLEN-1:2], 2'b00};

  always_comb begin
    new_status                    = item_i.status_in;
    new_status[MpieIdx]           = 1'b1;
    new_status[MieIdx]            = 1'b0;
    new_status[MppHiIdx:MppLoIdx] = 2'b11;
  end

  // The source bit in mip must still be clear, otherwise the entry waits.
  assign take = (item_i.func == FuncCheck) && pending_q && item_i.status_in[MieIdx]
             && ((item_i.enable_in & src_mask) != '0)
             && ((item_i.pend_in & src_mask) == '0);
  assign release_now = (item_i.func == FuncCheck) && !pending_q && !released_q;

  always_comb begin
    res_o = '0;
    if (take) begin
      res_o.taken      = 1'b1;
      res_o.pend_write = 1'b1;
      res_o.pend_out   = item_i.pend_in | src_mask;
      res_o.status_out = new_status;
      res_o.epc_out    = item_i.pc_in;
      res_o.cause_out  = cause_q;
      if (item_i.vector_in[1:0] == ModeVectored) begin
        res_o.pc_out = base + {{(XLEN-CodeW-2){1'b0}}, code, 2'b00};
      end else begin
        res_o.pc_out = base;
      end
    end else if (release_now) begin
      res_o.pend_write = 1'b1;
      res_o.pend_out   = item_i.pend_in & ~src_mask;
    end
  end

  always_comb begin
    pending_d  = pending_q;
    released_d = released_q;
    cause_d    = cause_q;
    if (fire) begin
      if (item_i.func == FuncRaise) begin
        pending_d = 1'b1;
        cause_d   = item_i.cause_in;
      end else if (take) begin
        pending_d  = 1'b0;
        released_d = 1'b0;
      end else if (release_now) begin
        released_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= 1'b0;
      released_q <= 1'b1;
      cause_q    <= '0;
    end else begin
      pending_q  <= pending_d;
      released_q <= released_d;
      cause_q    <= cause_d;
    end
  end

  a_take_writes_mip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.taken |-> (res_o.pend_write && res_o.status_out[MieIdx] == 1'b0))
    else $error("trap taken without the mip write or with MIE still set");

  a_take_arms_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && take) |=> (!pending_q && !released_q))
    else $error("state not updated after a trap was taken");

  a_release_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && release_now) |=> released_q)
    else $error("release did not complete");

  a_no_take_without_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pending_q |-> !res_o.taken)
    else $error("trap taken with nothing pending");

endmodule

`default_nettype wire

@@ rtl/core/mie_out_stage.sv @@
// ----------------------------------------------------------------------------
// mie_out_stage: result register
// Holds one result item for the master side until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_out_stage
  import mie_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pipe_ctrl_t ctrl_i,
  input  wire res_item_t  res_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output res_item_t       res_o
);

  logic      valid_q, valid_d;
  res_item_t res_q;
  logic      load;

  assign free_o  = !valid_q || out_ready_i;
  assign load    = ctrl_i.valid && ctrl_i.advance;
  assign valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ rtl/core/machine_interrupt_entry.sv @@
// ----------------------------------------------------------------------------
// machine_interrupt_entry: machine-mode interrupt entry for a 64-bit core
//
//   Channel  Direction  Payload
//   s_axis   in         tuser: func; tdata: cause, mstatus, mie, mip, mtvec, pc
//   m_axis   out        tuser: taken, pend_write; tdata: mip, mstatus, mepc,
//                       mcause, new pc
//
// One item is accepted per cycle while m_axis is not stalled; each item passes
// through the input register, then the trap logic, then the result register.
// After reset nothing is pending and no mip bit waits to be cleared.
// A stall on m_axis holds both stages and reaches s_axis_tready in the same
// cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module machine_interrupt_entry
  import mie_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // cause_in, status_in, enable_in, pend_in, vector_in, pc_in (lowest first)
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // func
  input  wire logic [0:0]          s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // pend_out, status_out, epc_out, cause_out, pc_out (lowest first)
  output logic [OutDataW-1:0]      m_axis_tdata,
  // taken, pend_write (lowest first)
  output logic [1:0]               m_axis_tuser
);

  in_item_t   s_item, s1_item;
  res_item_t  s2_res, out_res;
  pipe_ctrl_t s1_ctrl;
  logic       out_free;

  assign s_item.func      = func_e'(s_axis_tuser[0]);
  assign s_item.cause_in  = s_axis_tdata[1*XLEN-1:0*XLEN];
  assign s_item.status_in = s_axis_tdata[2*XLEN-1:1*XLEN];
  assign s_item.enable_in = s_axis_tdata[3*XLEN-1:2*XLEN];
  assign s_item.pend_in   = s_axis_tdata[4*XLEN-1:3*XLEN];
  assign s_item.vector_in = s_axis_tdata[5*XLEN-1:4*XLEN];
  assign s_item.pc_in     = s_axis_tdata[6*XLEN-1:5*XLEN];

  mie_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_item_i  (s_item),
    .in_ready_o (s_axis_tready),
    .advance_i  (out_free),
    .ctrl_o     (s1_ctrl),
    .item_o     (s1_item)
  );

  mie_trap_logic u_trap_logic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (s1_ctrl),
    .item_i (s1_item),
    .res_o  (s2_res)
  );

  mie_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (s1_ctrl),
    .res_i       (s2_res),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (out_res)
  );

  assign m_axis_tdata = {out_res.pc_out, out_res.cause_out, out_res.epc_out,
                         out_res.status_out, out_res.pend_out};
  assign m_axis_tuser = {out_res.pend_write, out_res.taken};

endmodule

`default_nettype wire
